FILE: hw/rtl/slfo_pkg.sv
// ----------------------------------------------------------------------------
// slfo_pkg
// Shared types, register codes and fixed-point helpers for the shaped LFO
// tremolo / auto-pan block.
// ----------------------------------------------------------------------------
package slfo_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_BITS   = 4;

  localparam logic [1:0] REG_DEPTH      = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [1:0] REG_MODE       = 2'd2;

  localparam logic [15:0] DEPTH_RESET = 16'd0;
  localparam logic [31:0] STEP_RESET  = 32'd9739;
  localparam logic [15:0] MODE_RESET  = 16'd0;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          last_frame_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          last_frame_out;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic pan;
  } lane_ctl_t;

  // q30 product with floor
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  // shift-subtract quotient of two positive values, table build only
  function automatic longint udiv_long(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r << 1) | ((n >> i) & 64'sd1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // linear interpolation between two table entries, 16-bit fraction
  function automatic logic signed [33:0] interp(input logic signed [31:0] lo,
                                                input logic signed [31:0] hi,
                                                input logic [15:0] f);
    logic signed [32:0] diff;
    logic signed [49:0] prod;
    diff = 33'(hi) - 33'(lo);
    prod = diff * $signed({1'b0, f});
    return 34'(lo) + 34'(prod >>> 16);
  endfunction

endpackage

FILE: hw/rtl/slfo_sin_rom.sv
// ----------------------------------------------------------------------------
// slfo_sin_rom
// Sine table in q2.30, two registered read ports.
// ----------------------------------------------------------------------------
module slfo_sin_rom #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                 clk,
  input  logic [AW-1:0]        addr_a,
  input  logic [AW-1:0]        addr_b,
  output logic signed [31:0]   data_a,
  output logic signed [31:0]   data_b
);

  typedef logic signed [31:0] tab_t [TABLE_DEPTH];

  // rotate (1,0) by one table step per entry
  function automatic tab_t build();
    tab_t   t;
    longint a, a2, a3, a4, a5, s0, c0, c, s, nc, ns;
    a  = 64'sd6746518852 / TABLE_DEPTH;
    a2 = slfo_pkg::qmul(a, a);
    a3 = slfo_pkg::qmul(a2, a);
    a4 = slfo_pkg::qmul(a2, a2);
    a5 = slfo_pkg::qmul(a3, a2);
    s0 = a - a3 / 6 + a5 / 120;
    c0 = (64'sd1 << 30) - a2 / 2 + a4 / 24;
    c  = 64'sd1 << 30;
    s  = 0;
    t[0] = '0;
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      nc = slfo_pkg::qmul(c, c0) - slfo_pkg::qmul(s, s0);
      ns = slfo_pkg::qmul(s, c0) + slfo_pkg::qmul(c, s0);
      c = nc;
      s = ns;
      t[i] = 32'(s);
    end
    return t;
  endfunction

  localparam tab_t TAB = build();

  always_ff @(posedge clk) begin
    data_a <= TAB[addr_a];
    data_b <= TAB[addr_b];
  end

endmodule

FILE: hw/rtl/slfo_tnh_rom.sv
// ----------------------------------------------------------------------------
// slfo_tnh_rom
// Tanh table over [0, 8] in q2.30, two registered read ports.
// ----------------------------------------------------------------------------
module slfo_tnh_rom #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = $clog2(TABLE_DEPTH) + 1
) (
  input  logic                 clk,
  input  logic [AW-1:0]        addr_a,
  input  logic [AW-1:0]        addr_b,
  output logic signed [31:0]   data_a,
  output logic signed [31:0]   data_b
);

  typedef logic signed [31:0] tab_t [TABLE_DEPTH+1];

  // tanh addition formula, one step per entry
  function automatic tab_t build();
    tab_t   t;
    longint h, h2, h3, h5, t0, cur, den;
    h   = (64'sd1 << 33) / TABLE_DEPTH;
    h2  = slfo_pkg::qmul(h, h);
    h3  = slfo_pkg::qmul(h2, h);
    h5  = slfo_pkg::qmul(h3, h2);
    t0  = h - h3 / 3 + (2 * h5) / 15;
    cur = 0;
    t[0] = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      den = (64'sd1 << 30) + slfo_pkg::qmul(cur, t0);
      cur = slfo_pkg::udiv_long((cur + t0) << 30, den);
      t[i+1] = 32'(cur);
    end
    return t;
  endfunction

  localparam tab_t TAB = build();

  always_ff @(posedge clk) begin
    data_a <= TAB[addr_a];
    data_b <= TAB[addr_b];
  end

endmodule

FILE: hw/rtl/slfo_div.sv
// ----------------------------------------------------------------------------
// slfo_div
// Restoring divider for the wave normalization: quo = (num << 30) / den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slfo_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] rem;
  logic [31:0] low;
  logic [31:0] dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, low[31]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // upper dividend bits start below the divisor, so 32 steps cover the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {3'b000, num[30:2]};
      low <= {num[1:0], 30'd0};
      dsr <= den;
      quo <= '0;
    end else if (busy) begin
      low <= {low[30:0], 1'b0};
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

FILE: hw/rtl/slfo_lane.sv
// ----------------------------------------------------------------------------
// slfo_lane
// One channel: pan gain lookup from its own sine table or the tremolo gain,
// clamp to q1.15 and scale the sample.
// ----------------------------------------------------------------------------
module slfo_lane #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  slfo_pkg::lane_ctl_t                    ctl,
  input  logic [32:0]                            vpos,
  input  logic [30:0]                            tgain,
  input  logic signed [slfo_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                   done,
  output logic signed [slfo_pkg::SAMPLE_BITS-1:0] result
);

  localparam int LTD = $clog2(TABLE_DEPTH);
  localparam int SB  = slfo_pkg::SAMPLE_BITS;

  logic [LTD-1:0]          addr_a;
  logic [LTD-1:0]          addr_b;
  logic signed [31:0]      rom_a;
  logic signed [31:0]      rom_b;

  logic                    v1, v2, v3;
  logic                    pan1, pan2;
  logic [30:0]             tg1, tg2;
  logic [15:0]             f1;
  logic signed [SB-1:0]    smp1, smp2, smp3;
  logic signed [33:0]      gsum;
  logic [15:0]             g15;
  logic signed [33:0]      gsel;
  logic signed [SB+16:0]   yprod;

  assign addr_a = vpos[32 -: LTD];
  assign addr_b = addr_a + LTD'(1);

  slfo_sin_rom #(.TABLE_DEPTH(TABLE_DEPTH)) u_rom (
    .clk   (clk),
    .addr_a(addr_a),
    .addr_b(addr_b),
    .data_a(rom_a),
    .data_b(rom_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= ctl.start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  assign gsel  = pan2 ? gsum : 34'(tg2);
  assign yprod = smp3 * $signed({1'b0, g15});

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      pan1 <= ctl.pan;
      tg1  <= tgain;
      smp1 <= sample;
      f1   <= vpos[32-LTD -: 16];
    end
    if (v1) begin
      gsum <= slfo_pkg::interp(rom_a, rom_b, f1);
      pan2 <= pan1;
      tg2  <= tg1;
      smp2 <= smp1;
    end
    if (v2) begin
      smp3 <= smp2;
      // clamp to [0, 1.0] then keep q1.15
      if (gsel < 0) begin
        g15 <= '0;
      end else if (gsel > 34'sd1073741824) begin
        g15 <= 16'd32768;
      end else begin
        g15 <= gsel[30:15];
      end
    end
    if (v3) begin
      result <= SB'(yprod >>> 15);
    end
  end

endmodule

FILE: hw/rtl/shaped_lfo_tremolo_autopan_core.sv
// ----------------------------------------------------------------------------
// shaped_lfo_tremolo_autopan_core
// Stereo tremolo / auto-pan driven by a tanh-shaped sine LFO.
//
// Usage: one stereo word enters on in_valid/in_stall and one modulated word
// leaves on out_valid/out_stall. Registers depth, phase_step and mode_setting
// sit on the APB port at 0x0, 0x4, 0x8; the user must write them only while
// the block is idle, which the block itself does not enforce. A word passes
// through table lookups of the LFO sine and two tanh values, a divider for
// the wave normalization, gain setup, then two channel lanes that look up pan
// gains or take the tremolo gain and scale the samples side by side, and the
// output load, which raises out_valid. The divider sets the rate; a new word
// is taken only once the previous one has moved into the output register.
// While the receiver stalls, the finished word waits in the output register
// and the next word is processed up to its final step. Reset clears the LFO
// phase, the registers (phase_step 9739) and all valid flags; the tables are
// constant and need no fill.
// ----------------------------------------------------------------------------
module shaped_lfo_tremolo_autopan_core #(
  parameter int PHASE_BITS  = 32,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  slfo_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output slfo_pkg::out_word_t               out_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slfo_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int LTD = $clog2(TABLE_DEPTH);
  localparam int TW  = LTD + 1;
  localparam int SB  = slfo_pkg::SAMPLE_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SINA = 4'd1;
  localparam logic [3:0] ST_SIND = 4'd2;
  localparam logic [3:0] ST_X    = 4'd3;
  localparam logic [3:0] ST_TNA  = 4'd4;
  localparam logic [3:0] ST_TND  = 4'd5;
  localparam logic [3:0] ST_TDA  = 4'd6;
  localparam logic [3:0] ST_TDD  = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_W    = 4'd9;
  localparam logic [3:0] ST_G    = 4'd10;
  localparam logic [3:0] ST_L    = 4'd11;
  localparam logic [3:0] ST_WAIT = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  logic [3:0]             state;
  logic [3:0]             state_next;

  logic [15:0]            depth;
  logic [31:0]            phase_step;
  logic [15:0]            mode_setting;
  logic [PHASE_BITS-1:0]  phase;

  logic                   pan;
  logic [19:0]            k16;
  logic [16:0]            dq;
  logic                   cfg_wr;

  // captured word
  logic signed [SB-1:0]   lat_l;
  logic signed [SB-1:0]   lat_r;
  logic                   lat_last;

  // phase sine lookup
  logic [LTD-1:0]              ps_addr_a;
  logic [LTD-1:0]              ps_addr_b;
  logic [PHASE_BITS+LTD-1:0]   ppos;
  logic signed [31:0]          ps_a;
  logic signed [31:0]          ps_b;
  logic signed [33:0]          s_val;
  logic                        s_neg;
  logic [32:0]                 s_mag;
  logic [52:0]                 xprod;
  logic [35:0]                 x;

  // tanh lookup
  logic [35:0]             targ;
  logic [LTD+2:0]          tidx;
  logic                    tover;
  logic [TW-1:0]           taddr_a;
  logic [TW-1:0]           taddr_b;
  logic signed [31:0]      tn_a;
  logic signed [31:0]      tn_b;
  logic signed [33:0]      tval;
  logic [30:0]             num_mag;
  logic                    wzero;

  // divider
  logic                    div_start;
  logic                    div_done;
  logic [31:0]             div_q;

  // wave and gains
  logic [31:0]             qv;
  logic [30:0]             wmag;
  logic signed [31:0]      wave;
  logic signed [32:0]      wsum;
  logic [30:0]             wu;
  logic [30:0]             wt;
  logic signed [49:0]      prod;
  logic signed [33:0]      pval;
  logic [32:0]             vl;
  logic [32:0]             vr;
  logic [31:0]             tg_full;
  logic [30:0]             tgain;

  slfo_pkg::lane_ctl_t     lane_ctl;
  logic                    done_l;
  logic                    done_r;
  logic signed [SB-1:0]    res_l;
  logic signed [SB-1:0]    res_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth        <= slfo_pkg::DEPTH_RESET;
      phase_step   <= slfo_pkg::STEP_RESET;
      mode_setting <= slfo_pkg::MODE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        slfo_pkg::REG_DEPTH:      depth        <= pwdata[15:0];
        slfo_pkg::REG_PHASE_STEP: phase_step   <= pwdata;
        slfo_pkg::REG_MODE:       mode_setting <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      slfo_pkg::REG_DEPTH:      prdata = {16'd0, depth};
      slfo_pkg::REG_PHASE_STEP: prdata = phase_step;
      slfo_pkg::REG_MODE:       prdata = {16'd0, mode_setting};
      default:                  prdata = 32'd0;
    endcase
  end

  assign pan = mode_setting[15];
  assign k16 = 20'd65536 + 20'({mode_setting[14:0], 1'b0}) * 20'd7;
  // full-scale depth counts as exactly one
  assign dq  = (depth == 16'hFFFF) ? 17'h10000 : {1'b0, depth};

  // lfo sine of the current phase
  assign ppos      = {phase, {LTD{1'b0}}};
  assign ps_addr_a = phase[PHASE_BITS-1 -: LTD];
  assign ps_addr_b = ps_addr_a + LTD'(1);

  slfo_sin_rom #(.TABLE_DEPTH(TABLE_DEPTH)) u_sin (
    .clk   (clk),
    .addr_a(ps_addr_a),
    .addr_b(ps_addr_b),
    .data_a(ps_a),
    .data_b(ps_b)
  );

  assign s_mag = s_val[33] ? 33'(-s_val) : 33'(s_val);
  assign xprod = 53'(s_mag) * 53'(k16);

  // tanh of x for the numerator, of k for the denominator
  assign targ    = (state == ST_TDA || state == ST_TDD) ? {2'b00, k16, 14'd0} : x;
  assign tidx    = targ[35 : 33-LTD];
  assign tover   = tidx >= (LTD+3)'(TABLE_DEPTH);
  assign taddr_a = tover ? TW'(TABLE_DEPTH) : tidx[TW-1:0];
  assign taddr_b = tover ? TW'(TABLE_DEPTH) : taddr_a + TW'(1);
  assign tval    = slfo_pkg::interp(tn_a, tn_b, targ[32-LTD -: 16]);

  slfo_tnh_rom #(.TABLE_DEPTH(TABLE_DEPTH)) u_tnh (
    .clk   (clk),
    .addr_a(taddr_a),
    .addr_b(taddr_b),
    .data_a(tn_a),
    .data_b(tn_b)
  );

  assign div_start = (state == ST_TDD) && (tval > 0);

  slfo_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_mag),
    .den  (32'(tval)),
    .done (div_done),
    .quo  (div_q)
  );

  assign qv   = wzero ? 32'd0 : div_q;
  assign wmag = (qv > 32'd1073741824) ? 31'd1073741824 : qv[30:0];

  assign wsum = 33'(wave) + 33'sd1073741824;
  assign wu   = wsum[31:1];
  assign wt   = 31'd1073741824 - wu;

  assign pval    = 34'(prod >>> 16);
  assign vr      = 33'(pval + 34'sd1073741824);
  assign vl      = 33'(34'sd1073741824 - pval);
  assign tg_full = 32'd1073741824 - 32'(prod[47:16]);
  assign tgain   = tg_full[30:0];

  assign lane_ctl.start = (state == ST_L);
  assign lane_ctl.pan   = pan;

  slfo_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_l (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .vpos  (vl),
    .tgain (tgain),
    .sample(lat_l),
    .done  (done_l),
    .result(res_l)
  );

  slfo_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_r (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .vpos  (vr),
    .tgain (tgain),
    .sample(lat_r),
    .done  (done_r),
    .result(res_r)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SINA;
      ST_SINA: state_next = ST_SIND;
      ST_SIND: state_next = ST_X;
      ST_X:    state_next = ST_TNA;
      ST_TNA:  state_next = ST_TND;
      ST_TND:  state_next = ST_TDA;
      ST_TDA:  state_next = ST_TDD;
      ST_TDD:  state_next = (tval > 0) ? ST_DIV : ST_W;
      ST_DIV:  if (div_done) state_next = ST_W;
      ST_W:    state_next = ST_G;
      ST_G:    state_next = ST_L;
      ST_L:    state_next = ST_WAIT;
      ST_WAIT: if (done_l && done_r) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // phase moves on only after the wave has taken its sine
      if (state == ST_SIND) begin
        phase <= phase + phase_step[PHASE_BITS-1:0];
      end
      if (state == ST_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      lat_l    <= in_word.left_in;
      lat_r    <= in_word.right_in;
      lat_last <= in_word.last_frame_in;
    end
    if (state == ST_SIND) begin
      s_val <= slfo_pkg::interp(ps_a, ps_b, ppos[PHASE_BITS-1 -: 16]);
    end
    if (state == ST_X) begin
      s_neg <= s_val[33];
      x     <= xprod[51:16];
    end
    if (state == ST_TND) begin
      num_mag <= tval[30:0];
    end
    if (state == ST_TDD) begin
      wzero <= !(tval > 0);
    end
    if (state == ST_W) begin
      wave <= s_neg ? -$signed({1'b0, wmag}) : $signed({1'b0, wmag});
    end
    if (state == ST_G) begin
      if (pan) begin
        prod <= wave * $signed({1'b0, dq});
      end else begin
        prod <= $signed(50'(dq * wt));
      end
    end
    if (state == ST_FIN && (!out_valid || !out_stall)) begin
      out_word.left_out       <= res_l;
      out_word.right_out      <= res_r;
      out_word.last_frame_out <= lat_last;
    end
  end

endmodule

FILE: tb/shaped_lfo_tremolo_autopan_core_test.sv
// ----------------------------------------------------------------------------
// shaped_lfo_tremolo_autopan_core_test
// Drives stereo words through the tremolo / auto-pan core under random
// idling on both sides, predicts every modulated word with an independent
// fixed-point LFO model and checks the outputs in order. Registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module shaped_lfo_tremolo_autopan_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BITS  = 32;
  localparam int TABLE_DEPTH = 1024;
  localparam longint ONE_Q30 = 64'sd1 << 30;

  // floor division by 2^n
  function automatic longint floor_shift(input longint x, input int n);
    return x >>> n;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return floor_shift(a * b, 30);
  endfunction

  class frame_scoreboard;
    longint sine_rom[TABLE_DEPTH];
    longint tanh_rom[TABLE_DEPTH+1];
    bit [15:0] depth_q;
    bit [31:0] step_q;
    bit [15:0] mode_q;
    bit [31:0] phase_acc;
    slfo_pkg::out_word_t pending[$];
    int errors;

    function new();
      longint a, a2, a3, a4, a5, s0, c0, c, s, nc, ns, h, h2, h3, h5, t0, den;
      a = 64'sd6746518852 / TABLE_DEPTH;
      a2 = q30_mul(a, a);
      a3 = q30_mul(a2, a);
      a4 = q30_mul(a2, a2);
      a5 = q30_mul(a3, a2);
      s0 = a - a3 / 6 + a5 / 120;
      c0 = ONE_Q30 - a2 / 2 + a4 / 24;
      c = ONE_Q30;
      s = 0;
      sine_rom[0] = 0;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
        nc = q30_mul(c, c0) - q30_mul(s, s0);
        ns = q30_mul(s, c0) + q30_mul(c, s0);
        c = nc;
        s = ns;
        sine_rom[i] = s;
      end
      h = (64'sd1 << 33) / TABLE_DEPTH;
      h2 = q30_mul(h, h);
      h3 = q30_mul(h2, h);
      h5 = q30_mul(h3, h2);
      t0 = h - h3 / 3 + (2 * h5) / 15;
      tanh_rom[0] = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        den = ONE_Q30 + q30_mul(tanh_rom[i], t0);
        tanh_rom[i+1] = ((tanh_rom[i] + t0) * ONE_Q30) / den;
      end
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      depth_q = slfo_pkg::DEPTH_RESET;
      step_q = slfo_pkg::STEP_RESET;
      mode_q = slfo_pkg::MODE_RESET;
      phase_acc = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input bit [31:0] val);
      case (idx)
        slfo_pkg::REG_DEPTH: depth_q = val[15:0];
        slfo_pkg::REG_PHASE_STEP: step_q = val;
        slfo_pkg::REG_MODE: mode_q = val[15:0];
        default: ;
      endcase
    endfunction

    function longint sine_lookup(input bit [63:0] pos, input int fbits);
      bit [63:0] idx, nxt;
      longint f, lo;
      idx = (pos >> fbits) % TABLE_DEPTH;
      nxt = (idx + 1 == TABLE_DEPTH) ? 0 : idx + 1;
      f = longint'((pos >> (fbits - 16)) & 64'hFFFF);
      lo = sine_rom[idx];
      return lo + floor_shift((sine_rom[nxt] - lo) * f, 16);
    endfunction

    function longint tanh_lookup(input bit [63:0] x);
      bit [63:0] pos, idx;
      longint f, lo;
      pos = x * TABLE_DEPTH;
      idx = pos >> 33;
      if (idx >= TABLE_DEPTH) return tanh_rom[TABLE_DEPTH];
      f = longint'((pos >> 17) & 64'hFFFF);
      lo = tanh_rom[idx];
      return lo + floor_shift((tanh_rom[idx+1] - lo) * f, 16);
    endfunction

    function logic signed [23:0] scale(input logic signed [23:0] smp, input longint g30);
      longint g15;
      if (g30 < 0) g30 = 0;
      if (g30 > ONE_Q30) g30 = ONE_Q30;
      g15 = g30 >>> 15;
      return 24'(floor_shift(longint'(smp) * g15, 15));
    endfunction

    function void note_input(input slfo_pkg::in_word_t w);
      bit pan;
      longint shape, k16, d, s, num, den, wave, gl, gr, u, p;
      bit [63:0] x;
      slfo_pkg::out_word_t r;
      pan = mode_q >= 16'd32768;
      shape = pan ? (longint'(mode_q) - 32768) * 2 : longint'(mode_q) * 2;
      k16 = 65536 + 7 * shape;
      d = (depth_q == 16'hFFFF) ? 65536 : longint'(depth_q);
      s = sine_lookup(64'(phase_acc) * TABLE_DEPTH, PHASE_BITS);
      x = (64'(s < 0 ? -s : s) * 64'(k16)) >> 16;
      num = tanh_lookup(x);
      if (s < 0) num = -num;
      den = tanh_lookup(64'(k16) << 14);
      wave = (den > 0) ? (num * ONE_Q30) / den : 0;
      if (wave > ONE_Q30) wave = ONE_Q30;
      if (wave < -ONE_Q30) wave = -ONE_Q30;
      phase_acc = phase_acc + step_q;
      if (!pan) begin
        u = (ONE_Q30 + wave) >>> 1;
        gl = ONE_Q30 - ((d * (ONE_Q30 - u)) >>> 16);
        gr = gl;
      end else begin
        p = floor_shift(wave * d, 16);
        gr = sine_lookup(64'(p + ONE_Q30) * TABLE_DEPTH, 33);
        gl = sine_lookup(64'(ONE_Q30 - p) * TABLE_DEPTH, 33);
      end
      r.left_out = scale(w.left_in, gl);
      r.right_out = scale(w.right_in, gr);
      r.last_frame_out = w.last_frame_in;
      pending.push_back(r);
    endfunction

    function void check_output(input slfo_pkg::out_word_t got);
      slfo_pkg::out_word_t want;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.left_out !== want.left_out) begin
        $error("left_out expected %0d actual %0d", want.left_out, got.left_out);
        errors++;
      end
      if (got.right_out !== want.right_out) begin
        $error("right_out expected %0d actual %0d", want.right_out, got.right_out);
        errors++;
      end
      if (got.last_frame_out !== want.last_frame_out) begin
        $error("last_frame_out expected %0d actual %0d", want.last_frame_out,
               got.last_frame_out);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  slfo_pkg::in_word_t in_word;
  slfo_pkg::out_word_t out_word;
  logic psel, penable, pwrite, pready;
  logic [slfo_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata, prdata;
  frame_scoreboard sb;
  bit calm;

  shaped_lfo_tremolo_autopan_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stall bursts, outputs checked at the edge
  initial begin
    int burst;
    out_stall = 0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_output(out_word);
      if (burst > 0) begin
        burst--;
        out_stall <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 12) - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic write_cfg(input logic [1:0] idx, input bit [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= slfo_pkg::ADDR_BITS'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_frame(input slfo_pkg::in_word_t w);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
  endtask

  function automatic slfo_pkg::in_word_t rand_frame();
    slfo_pkg::in_word_t w;
    w.left_in = 24'($urandom);
    w.right_in = 24'($urandom);
    w.last_frame_in = 1'($urandom);
    return w;
  endfunction

  function automatic logic signed [23:0] edge_sample(input int sel);
    case (sel)
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'sh000000;
      3: return 24'shFFFFFF;
      default: return 24'sh000001;
    endcase
  endfunction

  initial begin
    slfo_pkg::in_word_t w;
    bit [15:0] depths[5] = '{16'd0, 16'hFFFF, 16'hFFFE, 16'h8000, 16'h1234};
    bit [15:0] modes[6] = '{16'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'hC000};
    bit [31:0] steps[4] = '{32'd0, 32'hFFFFFFFF, 32'h0100_0000, 32'h0003_1234};
    sb = new();
    calm = 0;
    rst = 1;
    in_valid = 0;
    in_word = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings first, with extreme samples
    for (int i = 0; i < 5; i++) begin
      w.left_in = edge_sample(i);
      w.right_in = edge_sample(4 - i);
      w.last_frame_in = i[0];
      send_frame(w);
    end
    in_valid <= 0;
    drain();
    write_cfg(3, 32'hDEAD_BEEF);  // unmapped index, ignored

    // directed: full and near-full depth, both modes, sweep of phase
    for (int m = 0; m < 4; m++) begin
      write_cfg(slfo_pkg::REG_DEPTH, 32'(depths[m % 2 == 0 ? 1 : 2]));
      write_cfg(slfo_pkg::REG_MODE, 32'(modes[m]));
      write_cfg(slfo_pkg::REG_PHASE_STEP, 32'h1000_0000);
      for (int i = 0; i < 5; i++) begin
        w.left_in = edge_sample(i % 2);
        w.right_in = edge_sample(1 - i % 2);
        w.last_frame_in = i[0];
        send_frame(w);
      end
      in_valid <= 0;
      drain();
    end

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 13) calm = 1;
      write_cfg(slfo_pkg::REG_DEPTH,
                ph < 5 ? 32'(depths[ph]) : 32'($urandom_range(0, 65535)));
      write_cfg(slfo_pkg::REG_MODE,
                ph < 6 ? 32'(modes[ph]) : 32'($urandom_range(0, 65535)));
      write_cfg(slfo_pkg::REG_PHASE_STEP, ph < 4 ? steps[ph] : $urandom);
      for (int i = 0; i < 100; i++) begin
        send_frame(rand_frame());
        if (ph == 7 && i == 50) begin
          in_valid <= 0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
